FILE: rtl/gmps_pkg.sv
package gmps_pkg;

  // Board limits and field widths
  localparam int MAX_SIZE = 64;
  localparam int COL_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 7;
  localparam int CELL_W   = 16;
  localparam int SUM_W    = 22;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(MAX_SIZE);
  localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

  // Control carried from the issue stage to the update stage
  typedef struct packed {
    logic             first_row;
    logic             has_left;
    logic             has_right;
    logic             last_cell;
    logic [COL_W-1:0] col;
  } stage_ctrl_t;

endpackage

FILE: rtl/gmps_if.sv
interface gmps_cell_if;
  import gmps_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmps_result_if;
  import gmps_pkg::*;
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  best_sum;
  logic [SIZE_W-1:0] best_column;

  modport source (output valid, output best_sum, output best_column, input ready);
  modport sink   (input valid, input best_sum, input best_column, output ready);
endinterface

interface gmps_cfg_if;
  import gmps_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] board_size;

  modport source (output valid, output board_size, input ready);
  modport sink   (input valid, input board_size, output ready);
endinterface

FILE: rtl/grid_max_path_sum_unit.sv
// Channel  Dir  Payload                       Handshake
// cells    in   cell_value[15:0]              valid/ready
// result   out  best_sum[21:0], best_column   valid/ready
// cfg      in   board_size[6:0]               valid/ready, always ready
//
// One cell per cycle while the input is not stalled: issue stage reads the row buffer (two read ports),
// update stage forms the sum and writes it back.
// A board's result is registered in the output register once its last cell leaves the stage register.
// Synchronous reset clears counters, pipeline and output; board size goes to 8.
// Input stalls only when a second result is due while the first still waits.
module grid_max_path_sum_unit
  import gmps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  gmps_cell_if.sink    cells,
  gmps_result_if.source result,
  gmps_cfg_if.sink     cfg
);

  // Configuration
  logic [SIZE_W-1:0] board_size;
  logic [SIZE_W-1:0] size_n;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= SIZE_RESET;
    end else if (cfg.valid) begin
      board_size <= cfg.board_size;
    end
  end

  // Effective size: zero acts as one, clipped to the buffer depth
  always_comb begin
    if (board_size == '0) begin
      size_n = SIZE_W'(1);
    end else if (board_size > SIZE_LIMIT) begin
      size_n = SIZE_LIMIT;
    end else begin
      size_n = board_size;
    end
  end

  // Pipeline handshake
  logic              b_valid;
  stage_ctrl_t       b_ctrl;
  logic [CELL_W-1:0] b_cell;
  logic              b_fire;
  logic              in_take;

  assign b_fire   = b_valid && (!b_ctrl.last_cell || !result.valid || result.ready);
  assign cells.ready = !b_valid || b_fire;
  assign in_take  = cells.valid && cells.ready;

  // Issue stage: position counters
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              last_col;
  logic              last_row;

  assign col_inc  = {1'b0, col} + SIZE_W'(1);
  assign row_inc  = {1'b0, row} + SIZE_W'(1);
  assign last_col = (col_inc == size_n);
  assign last_row = (row_inc == size_n);

  always_ff @(posedge clk) begin
    if (rst || cfg.valid) begin
      col <= '0;
      row <= '0;
    end else if (in_take) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row_inc[COL_W-1:0];
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (cells.ready) begin
      b_valid <= cells.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      b_cell           <= cells.cell_value;
      b_ctrl.first_row <= (row == '0);
      b_ctrl.has_left  <= (col != '0);
      b_ctrl.has_right <= !last_col;
      b_ctrl.last_cell <= last_col && last_row;
      b_ctrl.col       <= col;
    end
  end

  // Row buffer: two reads at issue, one write at update, same-edge bypass
  logic [SUM_W-1:0] row_mem [MAX_SIZE];
  logic [SUM_W-1:0] rd_center;
  logic [SUM_W-1:0] rd_right;
  logic [COL_W-1:0] right_addr;
  logic [SUM_W-1:0] sum;

  assign right_addr = col_inc[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (b_fire) begin
      row_mem[b_ctrl.col] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_center <= (b_fire && b_ctrl.col == col) ? sum : row_mem[col];
      rd_right  <= (b_fire && b_ctrl.col == right_addr) ? sum : row_mem[right_addr];
    end
  end

  // Update stage: best of up to three neighbours plus the cell, saturated; first row uses the cell
  logic [SUM_W-1:0] window_left;
  logic [SUM_W-1:0] best_up;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] row_best_sum;
  logic [SIZE_W-1:0] row_best_column;
  logic             take_new;
  logic [SIZE_W-1:0] col_1based;

  always_comb begin
    best_up = rd_center;
    if (b_ctrl.has_left && window_left > best_up) begin
      best_up = window_left;
    end
    if (b_ctrl.has_right && rd_right > best_up) begin
      best_up = rd_right;
    end
    sum_wide = {1'b0, best_up} + (SUM_W+1)'(b_cell);
    if (b_ctrl.first_row) begin
      sum = SUM_W'(b_cell);
    end else if (sum_wide[SUM_W]) begin
      sum = SUM_MAX;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
  end

  assign take_new   = !b_ctrl.has_left || (sum > row_best_sum);
  assign col_1based = {1'b0, b_ctrl.col} + SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (b_fire) begin
      window_left <= rd_center;
      if (take_new) begin
        row_best_sum    <= sum;
        row_best_column <= col_1based;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (b_fire && b_ctrl.last_cell) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_ctrl.last_cell) begin
      result.best_sum    <= take_new ? sum : row_best_sum;
      result.best_column <= take_new ? col_1based : row_best_column;
    end
  end

endmodule

FILE: rtl/gmps_checker.sv
module gmps_checker
  import gmps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cell_valid,
  input logic              cell_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [SUM_W-1:0]  res_sum,
  input logic [SIZE_W-1:0] res_column
);

  // A waiting result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before taken");

  // A waiting result keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_sum) && $stable(res_column))
    else $error("result payload changed while stalled");

  // A fresh result follows a taken cell, which passed through the stage register
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cell_valid && cell_ready, 2))
    else $error("result without a matching cell");

  // Column lies on the board
  a_res_column: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_column != '0 && res_column <= SIZE_LIMIT))
    else $error("result column out of range");

endmodule

bind grid_max_path_sum_unit gmps_checker u_gmps_checker (
  .clk        (clk),
  .rst        (rst),
  .cell_valid (cells.valid),
  .cell_ready (cells.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_sum    (result.best_sum),
  .res_column (result.best_column)
);
